// ----- sv/rxrb_pkg.sv -----
// ----------------------------------------------------------------------------
// rxrb_pkg
// Shared types and constants for the receive ring buffer with frame drain.
// ----------------------------------------------------------------------------
package rxrb_pkg;

  // ring geometry
  localparam int DEPTH = 64;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // fixed field widths
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int CFG_IDX_W = 1;

  // reset values of the terminator registers
  localparam logic [BYTE_W-1:0] TERM_FIRST_RST  = 8'hEE;
  localparam logic [BYTE_W-1:0] TERM_SECOND_RST = 8'hFF;

  // item kinds
  localparam logic KIND_STORE = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TERM_FIRST  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TERM_SECOND = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] rx_byte;
    logic              require_frame;
  } in_item_t;

  typedef struct packed {
    logic              [BYTE_W-1:0] out_byte;
    logic                           has_data;
    logic              [LEN_W-1:0]  drained_length;
    logic                           last;
    logic                           overflowed;
  } out_item_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } state_t;

  // ring pointer advance with wrap
  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

// ----- sv/rx_ring_buffer_frame_drain_core.sv -----
// ----------------------------------------------------------------------------
// rx_ring_buffer_frame_drain_core
// Receive ring buffer: stores bytes, drains all of them in arrival order on
// request, optionally only once the terminator pair has been stored.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------
//   in      | input     | in_valid / in_stall   | in_data  (in_item_t)
//   out     | output    | out_valid / out_stall | out_data (out_item_t)
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A drain of n bytes moves to the drain state at the transfer, then loads
// one result per cycle into the result register while the output is not
// stalled, paced by the registered read data of the byte RAM. An empty or
// refused drain loads its single result at the transfer edge.
// Reset clears pointers, count and flags; RAM contents are not cleared.
// Output stall holds the result register and the drain sequencer.
// ----------------------------------------------------------------------------
module rx_ring_buffer_frame_drain_core
  import rxrb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  state_t state_r, state_nxt;

  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  remain_r, remain_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic              seen_r, seen_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ovf_snap_r, ovf_snap_nxt;
  logic [BYTE_W-1:0] last_byte_r, last_byte_nxt;
  logic [BYTE_W-1:0] term_first_r, term_second_r;

  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              in_xfer;
  logic              out_free;
  logic              ram_wr_en;
  logic [PTR_W-1:0]  ram_rd_addr;
  logic [BYTE_W-1:0] ram_rd_data;

  // byte store
  rxrb_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (in_data.rx_byte),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // handshakes
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE) || !out_free;
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // terminator registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_first_r  <= TERM_FIRST_RST;
      term_second_r <= TERM_SECOND_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TERM_FIRST:  term_first_r  <= cfg_data;
        REG_TERM_SECOND: term_second_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // state and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      count_r     <= '0;
      remain_r    <= '0;
      seen_r      <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      count_r     <= count_nxt;
      remain_r    <= remain_nxt;
      seen_r      <= seen_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    len_r       <= len_nxt;
    ovf_snap_r  <= ovf_snap_nxt;
    last_byte_r <= last_byte_nxt;
    out_data_r  <= out_data_nxt;
  end

  // next state, ring update and drain sequencing
  always_comb begin
    state_nxt     = state_r;
    rd_ptr_nxt    = rd_ptr_r;
    wr_ptr_nxt    = wr_ptr_r;
    count_nxt     = count_r;
    remain_nxt    = remain_r;
    len_nxt       = len_r;
    seen_nxt      = seen_r;
    ovf_nxt       = ovf_r;
    ovf_snap_nxt  = ovf_snap_r;
    last_byte_nxt = last_byte_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_wr_en     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_data.kind == KIND_STORE) begin
            // store a byte, or drop it when full
            if (count_r == CNT_W'(DEPTH)) begin
              ovf_nxt = 1'b1;
            end else begin
              if (count_r != '0 && in_data.rx_byte == term_second_r &&
                  last_byte_r == term_first_r) begin
                seen_nxt = 1'b1;
              end
              ram_wr_en     = 1'b1;
              last_byte_nxt = in_data.rx_byte;
              wr_ptr_nxt    = ptr_next(wr_ptr_r);
              count_nxt     = count_r + CNT_W'(1);
            end
          end else if (count_r == '0 || (in_data.require_frame && !seen_r)) begin
            // empty or refused drain: single marker result
            out_valid_nxt               = 1'b1;
            out_data_nxt.out_byte       = '0;
            out_data_nxt.has_data       = 1'b0;
            out_data_nxt.drained_length = '0;
            out_data_nxt.last           = 1'b1;
            out_data_nxt.overflowed     = ovf_r;
          end else begin
            // start a drain of the whole ring
            len_nxt      = count_r;
            remain_nxt   = count_r;
            ovf_snap_nxt = ovf_r;
            count_nxt    = '0;
            seen_nxt     = 1'b0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // RAM output holds the entry at rd_ptr_r
        if (out_free) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.out_byte       = ram_rd_data;
          out_data_nxt.has_data       = 1'b1;
          out_data_nxt.drained_length = LEN_W'(len_r);
          out_data_nxt.last           = (remain_r == CNT_W'(1));
          out_data_nxt.overflowed     = ovf_snap_r;
          rd_ptr_nxt                  = ptr_next(rd_ptr_r);
          remain_nxt                  = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // read ahead at the pointer for the next cycle
    ram_rd_addr = rd_ptr_nxt;
  end

endmodule

// ----- sv/rxrb_ram.sv -----
// ----------------------------------------------------------------------------
// rxrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rxrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
